/* rtl/reaction_wheel_attitude_observer_defines.svh */
// ----------------------------------------------------------------------------
// reaction_wheel_attitude_observer_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef REACTION_WHEEL_ATTITUDE_OBSERVER_DEFINES_SVH
`define REACTION_WHEEL_ATTITUDE_OBSERVER_DEFINES_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define RWAO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, disabled in reset
`define RWAO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rwao_pkg.sv */
// ----------------------------------------------------------------------------
// rwao_pkg
// constants, tables and helpers of the tilt observer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwao_pkg;

  localparam int CAL_SAMPLES_DEF = 200;

  localparam int QFRAC   = 16;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int WIDE_W  = 72;
  localparam int CW      = 36;
  localparam int ZW      = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic signed [ZW-1:0] Q_PI      = 20'sd205887;
  localparam logic signed [ZW-1:0] Q_HALF_PI = 20'sd102944;

  localparam logic [CFG_IDX_W-1:0] CFG_COULOMB   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INER  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SQ   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN = 4'd7;

  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:  v = 16'd51472;
      4'd1:  v = 16'd30386;
      4'd2:  v = 16'd16055;
      4'd3:  v = 16'd8150;
      4'd4:  v = 16'd4091;
      4'd5:  v = 16'd2047;
      4'd6:  v = 16'd1024;
      4'd7:  v = 16'd512;
      4'd8:  v = 16'd256;
      4'd9:  v = 16'd128;
      4'd10: v = 16'd64;
      4'd11: v = 16'd32;
      4'd12: v = 16'd16;
      4'd13: v = 16'd8;
      4'd14: v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic fits;
    fits = (&x[WIDE_W-1:31]) || ~(|x[WIDE_W-1:31]);
    if (fits) return x[31:0];
    else if (x[WIDE_W-1]) return 32'sh8000_0000;
    else return 32'sh7FFF_FFFF;
  endfunction

endpackage

/* rtl/reaction_wheel_attitude_observer.sv */
// ----------------------------------------------------------------------------
// reaction_wheel_attitude_observer
// single-axis tilt observer: wheel friction predict plus cordic correct
// ----------------------------------------------------------------------------
// estimate item: friction, predict, 16 cordic steps (skipped with both accel
//   inputs zero) and gain correct, multiplies on the shared 34x34 multiplier
// calibration item: one reciprocal multiply on the shared multiplier
// in_stall holds off a new item until the last one is done; a held result stalls
//   the next item in its final state
// synchronous reset clears state, estimates, gyro bias, config and out_valid
`timescale 1ns / 1ps

module reaction_wheel_attitude_observer
  import rwao_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic signed [31:0]   motor_torque,
  input  logic signed [31:0]   wheel_speed,
  input  logic signed [31:0]   accel_y,
  input  logic signed [31:0]   accel_z,
  input  logic signed [31:0]   gyro_x,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   angle_est,
  output logic signed [31:0]   rate_est,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // reciprocal of the sample count, exact for 32-bit magnitudes
  localparam int DIV_SH = 32 + $clog2(CAL_SAMPLES);
  localparam logic [32:0] RECIP = 33'((64'd1 << DIV_SH) / 64'(CAL_SAMPLES) + 64'd1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIV     = 5'd1;
  localparam logic [4:0] S_BIAS    = 5'd2;
  localparam logic [4:0] S_F0      = 5'd3;
  localparam logic [4:0] S_F1      = 5'd4;
  localparam logic [4:0] S_F2      = 5'd5;
  localparam logic [4:0] S_F3      = 5'd6;
  localparam logic [4:0] S_F4      = 5'd7;
  localparam logic [4:0] S_DIFF    = 5'd8;
  localparam logic [4:0] S_ACC_MUL = 5'd9;
  localparam logic [4:0] S_ACC     = 5'd10;
  localparam logic [4:0] S_P0      = 5'd11;
  localparam logic [4:0] S_P1      = 5'd12;
  localparam logic [4:0] S_P2      = 5'd13;
  localparam logic [4:0] S_P3      = 5'd14;
  localparam logic [4:0] S_CINIT   = 5'd15;
  localparam logic [4:0] S_CITER   = 5'd16;
  localparam logic [4:0] S_G0      = 5'd17;
  localparam logic [4:0] S_G1      = 5'd18;
  localparam logic [4:0] S_G2      = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  logic [4:0] state;
  logic [4:0] cnt;

  logic [30:0]        coulomb_friction, viscous_coeff, drag_coeff;
  logic signed [31:0] inv_inertia;
  logic [15:0]        step_time, half_step_sq;
  logic [16:0]        angle_gain, rate_gain;

  logic signed [31:0] tilt_angle, tilt_rate, gyro_bias;

  logic signed [31:0] tau, ay, az, gx;
  logic               wneg, wzero;
  logic [31:0]        aw;
  logic [47:0]        sq;
  logic [63:0]        mag;
  logic signed [31:0] diff, acc;
  logic signed [WIDE_W-1:0] na;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic signed [PROD_W-1:0] prod;
  logic [31:0]        dvd;

  logic signed [MUL_W-1:0] ma, mb;
  logic signed [WIDE_W-1:0] prod_q;
  logic [30:0]        mag_sat;
  logic signed [WIDE_W-1:0] fric;
  logic signed [CW-1:0] x0, y0, dx, dy;
  logic signed [ZW-1:0] at_step, m_ang;
  logic signed [WIDE_W-1:0] quot;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign prod_q  = WIDE_W'(prod >>> QFRAC);
  assign mag_sat = (|mag[63:31]) ? 31'h7FFF_FFFF : mag[30:0];
  assign fric    = wzero ? '0
                 : (wneg ? -WIDE_W'($signed({1'b0, mag_sat}))
                         :  WIDE_W'($signed({1'b0, mag_sat})));
  assign x0      = -CW'(az);
  assign y0      = -CW'(ay);
  assign dx      = cy >>> cnt[3:0];
  assign dy      = cx >>> cnt[3:0];
  assign at_step = ZW'($signed({1'b0, atan_entry(cnt[3:0])}));
  assign m_ang   = (cz > Q_PI) ? Q_PI : ((cz < -Q_PI) ? -Q_PI : cz);
  assign quot    = gx[31] ? -WIDE_W'(prod >>> DIV_SH)
                          :  WIDE_W'(prod >>> DIV_SH);

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_DIV: begin
        ma = MUL_W'($signed({1'b0, dvd}));
        mb = MUL_W'($signed({1'b0, RECIP}));
      end
      S_F0: begin
        ma = MUL_W'($signed({1'b0, aw}));
        mb = MUL_W'($signed({1'b0, aw}));
      end
      S_F1: begin
        ma = MUL_W'($signed({1'b0, viscous_coeff}));
        mb = MUL_W'($signed({1'b0, aw}));
      end
      S_F2: begin
        ma = MUL_W'($signed({1'b0, drag_coeff}));
        mb = MUL_W'($signed({1'b0, sq[47:16]}));
      end
      S_F3: begin
        ma = MUL_W'($signed({1'b0, drag_coeff}));
        mb = MUL_W'($signed({1'b0, sq[15:0]}));
      end
      S_ACC_MUL: begin
        ma = MUL_W'(inv_inertia);
        mb = MUL_W'(diff);
      end
      S_P0: begin
        ma = MUL_W'(tilt_rate);
        mb = MUL_W'($signed({1'b0, step_time}));
      end
      S_P1: begin
        ma = MUL_W'(acc);
        mb = MUL_W'($signed({1'b0, half_step_sq}));
      end
      S_P2: begin
        ma = MUL_W'(acc);
        mb = MUL_W'($signed({1'b0, step_time}));
      end
      S_G0: begin
        ma = MUL_W'($signed({1'b0, angle_gain}));
        mb = MUL_W'(m_ang) - MUL_W'(tilt_angle);
      end
      S_G1: begin
        ma = MUL_W'($signed({1'b0, rate_gain}));
        mb = MUL_W'(gx) - MUL_W'(gyro_bias) - MUL_W'(tilt_rate);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coulomb_friction <= '0;
      viscous_coeff    <= '0;
      drag_coeff       <= '0;
      inv_inertia      <= '0;
      step_time        <= '0;
      half_step_sq     <= '0;
      angle_gain       <= '0;
      rate_gain        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COULOMB:   coulomb_friction <= cfg_data[30:0];
        CFG_VISCOUS:   viscous_coeff    <= cfg_data[30:0];
        CFG_DRAG:      drag_coeff       <= cfg_data[30:0];
        CFG_INV_INER:  inv_inertia      <= cfg_data;
        CFG_STEP:      step_time        <= cfg_data[15:0];
        CFG_HALF_SQ:   half_step_sq     <= cfg_data[15:0];
        CFG_ANG_GAIN:  angle_gain       <= cfg_data[16:0];
        CFG_RATE_GAIN: rate_gain        <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          tau   <= motor_torque;
          ay    <= accel_y;
          az    <= accel_z;
          gx    <= gyro_x;
          wneg  <= wheel_speed[31];
          wzero <= (wheel_speed == 32'sd0);
          aw    <= wheel_speed[31] ? 32'(-wheel_speed) : wheel_speed;
          dvd   <= gyro_x[31] ? 32'(-gyro_x) : gyro_x;
        end
      end
      S_F1: begin
        sq  <= prod[63:16];
        mag <= 64'(coulomb_friction);
      end
      S_F2: mag <= mag + 64'(prod[63:16]);
      S_F3: mag <= mag + prod[63:0];
      S_F4: mag <= mag + 64'(prod[63:16]);
      S_DIFF: diff <= sat32(fric - WIDE_W'(tau));
      S_ACC: acc <= sat32(prod_q);
      S_P1: na <= WIDE_W'(tilt_angle) + prod_q;
      S_P2: na <= na + prod_q;
      S_CINIT: begin
        if (ay == 32'sd0 && az == 32'sd0) begin
          cx <= '0;
          cy <= '0;
          cz <= '0;
        end else if (x0 < 0) begin
          if (y0 >= 0) begin
            cx <= y0;
            cy <= -x0;
            cz <= Q_HALF_PI;
          end else begin
            cx <= -y0;
            cy <= x0;
            cz <= -Q_HALF_PI;
          end
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      S_CITER: begin
        if (!cy[CW-1]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at_step;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at_step;
        end
      end
      default: ;
    endcase
  end

  // sequencer, estimator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      tilt_angle <= '0;
      tilt_rate  <= '0;
      gyro_bias  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cnt   <= '0;
            state <= req_type ? S_F0 : S_DIV;
          end
        end
        S_DIV: state <= S_BIAS;
        S_BIAS: begin
          gyro_bias <= sat32(WIDE_W'(gyro_bias) + quot);
          state     <= S_FIN;
        end
        S_F0:      state <= S_F1;
        S_F1:      state <= S_F2;
        S_F2:      state <= S_F3;
        S_F3:      state <= S_F4;
        S_F4:      state <= S_DIFF;
        S_DIFF:    state <= S_ACC_MUL;
        S_ACC_MUL: state <= S_ACC;
        S_ACC:     state <= S_P0;
        S_P0:      state <= S_P1;
        S_P1:      state <= S_P2;
        S_P2:      state <= S_P3;
        S_P3: begin
          tilt_rate  <= sat32(WIDE_W'(tilt_rate) + prod_q);
          tilt_angle <= sat32(na);
          state      <= S_CINIT;
        end
        S_CINIT: begin
          cnt   <= '0;
          state <= (ay == 32'sd0 && az == 32'sd0) ? S_G0 : S_CITER;
        end
        S_CITER: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(CORDIC_STEPS - 1)) state <= S_G0;
        end
        S_G0: state <= S_G1;
        S_G1: begin
          tilt_angle <= sat32(WIDE_W'(tilt_angle) + prod_q);
          state      <= S_G2;
        end
        S_G2: begin
          tilt_rate <= sat32(WIDE_W'(tilt_rate) + prod_q);
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            angle_est <= tilt_angle;
            rate_est  <= tilt_rate;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rwao_checker.sv */
// ----------------------------------------------------------------------------
// rwao_checker
// port-level checks of the tilt observer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reaction_wheel_attitude_observer_defines.svh"

module rwao_checker
  import rwao_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] angle_est,
  input logic signed [31:0] rate_est
);

  // held result stays put
  `RWAO_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(angle_est) && $stable(rate_est))

  // an accepted item keeps the block busy
  `RWAO_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

  // no result appears right after a transfer
  `RWAO_ASSERT_NXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

  // back to idle only with a result on the output
  `RWAO_ASSERT_IMP(a_idle_with_result, $fell(in_stall), out_valid)

endmodule

bind reaction_wheel_attitude_observer rwao_checker u_rwao_checker (.*);
